@@ hdl/cmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Credential match table package
// Shared widths, request and status codes, and the byte mask helper.
// ----------------------------------------------------------------------------
package cmt_pkg;

    // Table geometry.
    localparam int SLOTS      = 16;
    localparam int PIN_DIGITS = 8;
    localparam int UID_BYTES  = 8;

    // Field widths.
    localparam int SLOT_W    = 4;
    localparam int SLOT_CAP  = 2 ** SLOT_W;
    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int LEN_W     = 4;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_SET_PIN   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEL_PIN   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_RFID  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_RFID  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CHK_PIN   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CHK_RFID  = 3'd5;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FMT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CHARS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_LEN   = 1'b1;

    // ASCII digit bounds.
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // One result of a request.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                slot_found;
        logic [SLOT_W-1:0]   match_slot;
        logic                is_master;
    } result_t;

    // Mask that keeps the lowest n bytes of a key word.
    function automatic logic [KEY_W-1:0] low_bytes_mask(input logic [LEN_W-1:0] n);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (LEN_W'(i) < n)
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ hdl/cmt_if.sv @@
// ----------------------------------------------------------------------------
// Credential match table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cmt_req_if;
    import cmt_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   pin_chars;
    logic [LEN_W-1:0]   pin_len;
    logic [KEY_W-1:0]   uid_bytes;
    logic [LEN_W-1:0]   uid_len;

    modport source (output valid, req_type, slot, pin_chars, pin_len, uid_bytes, uid_len,
                    input ready);
    modport sink   (input valid, req_type, slot, pin_chars, pin_len, uid_bytes, uid_len,
                    output ready);
endinterface

interface cmt_rsp_if;
    import cmt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                slot_found;
    logic [SLOT_W-1:0]   match_slot;
    logic                is_master;

    modport source (output valid, status, slot_found, match_slot, is_master, input ready);
    modport sink   (input valid, status, slot_found, match_slot, is_master, output ready);
endinterface

@@ hdl/credential_match_table.sv @@
// ----------------------------------------------------------------------------
// Credential match table
// PIN and RFID slot tables for a door lock with set, delete and check requests.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Carries
//   req       in         valid/ready    req_type, slot, pin_chars, pin_len,
//                                       uid_bytes, uid_len
//   rsp       out        valid/ready    status, slot_found, match_slot, is_master
//   cfg       in         cfg_we         cfg_index, cfg_wdata (master PIN)
//
// A set, delete or rejected request goes straight to the finish state: its
// result is registered at acceptance and moves to the output register when
// that register is free, and the block then returns to idle for the next one.
// A check request walks the slots through one shared entry comparator, one
// slot per cycle, visiting up to SLOTS slots before the finish state. A master
// PIN hit skips the walk. Reset clears the valid bits of both tables at once,
// so the block is ready as soon as reset is released. The next request is
// taken as soon as the previous result sits in the output register; a stalled
// response holds the following result in the finish state until it drains.
//
module credential_match_table (
    input  logic                          clk,
    input  logic                          rst_n,
    cmt_req_if.sink                       req,
    cmt_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [cmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmt_pkg::KEY_W-1:0]     cfg_wdata
);
    import cmt_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;

    // Request context captured at acceptance for the slot walk.
    logic              rfid_sel_reg, rfid_sel_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    result_t           res_reg, res_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    // Master PIN configuration.
    logic [KEY_W-1:0]  master_chars_reg;
    logic [LEN_W-1:0]  master_len_reg;

    // Tables. The valid bits reset; the contents are only ever read behind them.
    logic [SLOT_CAP-1:0] pin_vld_reg, pin_vld_next;
    logic [SLOT_CAP-1:0] rfid_vld_reg, rfid_vld_next;
    logic [LEN_W-1:0]    pin_len_reg  [SLOT_CAP];
    logic [KEY_W-1:0]    pin_dat_reg  [SLOT_CAP];
    logic [LEN_W-1:0]    rfid_len_reg [SLOT_CAP];
    logic [KEY_W-1:0]    rfid_dat_reg [SLOT_CAP];

    logic              pin_wr, rfid_wr;
    logic              accept;
    logic              slot_ok, pin_ok, uid_ok, master_hit;
    logic [KEY_W-1:0]  pin_mask, uid_mask, pin_key, uid_key;

    // Shared entry comparator operands.
    logic              ent_vld;
    logic [LEN_W-1:0]  ent_len;
    logic [KEY_W-1:0]  ent_dat;
    logic              ent_hit;
    logic              out_free;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;

    // Request format checks.
    assign slot_ok  = ({1'b0, req.slot} < (SLOT_W + 1)'(SLOTS));
    assign uid_ok   = (req.uid_len != '0) && (req.uid_len <= LEN_W'(UID_BYTES));
    assign pin_mask = low_bytes_mask(req.pin_len);
    assign uid_mask = low_bytes_mask(req.uid_len);
    assign pin_key  = req.pin_chars & pin_mask;
    assign uid_key  = req.uid_bytes & uid_mask;

    always_comb
    begin
        logic [7:0] ch;
        pin_ok = (req.pin_len != '0) && (req.pin_len <= LEN_W'(PIN_DIGITS));
        for (int i = 0; i < KEY_BYTES; i++) begin
            ch = req.pin_chars[8*i +: 8];
            if ((LEN_W'(i) < req.pin_len) && ((ch < CHAR_ZERO) || (ch > CHAR_NINE)))
            begin
                pin_ok = 1'b0;
            end
        end
    end

    assign master_hit = (master_len_reg != '0) && (master_len_reg == req.pin_len) &&
                        ((master_chars_reg & pin_mask) == pin_key);

    // The one comparator that the walk reuses for every slot of either table.
    always_comb
    begin
        if (rfid_sel_reg)
        begin
            ent_vld = rfid_vld_reg[idx_reg];
            ent_len = rfid_len_reg[idx_reg];
            ent_dat = rfid_dat_reg[idx_reg];
        end
        else
        begin
            ent_vld = pin_vld_reg[idx_reg];
            ent_len = pin_len_reg[idx_reg];
            ent_dat = pin_dat_reg[idx_reg];
        end
        ent_hit = ent_vld && (ent_len == len_reg) && (ent_dat == key_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rfid_sel_next  = rfid_sel_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        pin_vld_next   = pin_vld_reg;
        rfid_vld_next  = rfid_vld_reg;
        pin_wr         = 1'b0;
        rfid_wr        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    idx_next   = '0;
                    state_next = S_FINISH;
                    unique case (req.req_type)
                        REQ_SET_PIN:
                        begin
                            if (!slot_ok)
                                res_next.status = ST_BAD_SLOT;
                            else if (!pin_ok)
                                res_next.status = ST_BAD_FMT;
                            else
                            begin
                                pin_wr                 = 1'b1;
                                pin_vld_next[req.slot] = 1'b1;
                            end
                        end
                        REQ_DEL_PIN:
                        begin
                            if (!slot_ok)
                                res_next.status = ST_BAD_SLOT;
                            else
                                pin_vld_next[req.slot] = 1'b0;
                        end
                        REQ_SET_RFID:
                        begin
                            if (!slot_ok)
                                res_next.status = ST_BAD_SLOT;
                            else if (!uid_ok)
                                res_next.status = ST_BAD_FMT;
                            else
                            begin
                                rfid_wr                 = 1'b1;
                                rfid_vld_next[req.slot] = 1'b1;
                            end
                        end
                        REQ_DEL_RFID:
                        begin
                            if (!slot_ok)
                                res_next.status = ST_BAD_SLOT;
                            else
                                rfid_vld_next[req.slot] = 1'b0;
                        end
                        REQ_CHK_PIN:
                        begin
                            if (!pin_ok)
                                res_next.status = ST_BAD_FMT;
                            else if (master_hit)
                                res_next.is_master = 1'b1;
                            else
                            begin
                                res_next.status = ST_NO_MATCH;
                                rfid_sel_next   = 1'b0;
                                key_next        = pin_key;
                                len_next        = req.pin_len;
                                state_next      = S_SCAN;
                            end
                        end
                        REQ_CHK_RFID:
                        begin
                            if (!uid_ok)
                                res_next.status = ST_BAD_FMT;
                            else
                            begin
                                res_next.status = ST_NO_MATCH;
                                rfid_sel_next   = 1'b1;
                                key_next        = uid_key;
                                len_next        = req.uid_len;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_BAD_FMT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // The lowest matching slot wins, so the walk stops at the first hit.
                if (ent_hit)
                begin
                    res_next.status     = ST_OK;
                    res_next.slot_found = 1'b1;
                    res_next.match_slot = idx_reg;
                    state_next          = S_FINISH;
                end
                else if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
            pin_vld_reg      <= '0;
            rfid_vld_reg     <= '0;
            master_chars_reg <= '0;
            master_len_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            pin_vld_reg   <= pin_vld_next;
            rfid_vld_reg  <= rfid_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MASTER_CHARS: master_chars_reg <= cfg_wdata;
                    CFG_MASTER_LEN:   master_len_reg   <= cfg_wdata[LEN_W-1:0];
                    default:          master_len_reg   <= master_len_reg;
                endcase
            end
        end
    end

    // Payload registers and table contents.
    always_ff @(posedge clk)
    begin
        rfid_sel_reg <= rfid_sel_next;
        key_reg      <= key_next;
        len_reg      <= len_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        if (pin_wr)
        begin
            pin_len_reg[req.slot] <= req.pin_len;
            pin_dat_reg[req.slot] <= pin_key;
        end
        if (rfid_wr)
        begin
            rfid_len_reg[req.slot] <= req.uid_len;
            rfid_dat_reg[req.slot] <= uid_key;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.slot_found = out_reg.slot_found;
    assign rsp.match_slot = out_reg.match_slot;
    assign rsp.is_master  = out_reg.is_master;

endmodule
